FILE: hw/rtl/bls_pkg.sv
package bls_pkg;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned MaxResults = 16;

  localparam int unsigned OpW    = 4;
  localparam int unsigned ValW   = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR    = 4'd0,
    OP_INS_HEAD = 4'd1,
    OP_INS_TAIL = 4'd2,
    OP_DEL_HEAD = 4'd3,
    OP_DEL_TAIL = 4'd4,
    OP_SEARCH   = 4'd5,
    OP_SRCH_DEL = 4'd6,
    OP_SORT_UP  = 4'd7,
    OP_SORT_DN  = 4'd8,
    OP_DUMP     = 4'd9
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIND_RD,
    S_FIND_CMP,
    S_SORT_RD,
    S_SORT_CMP,
    S_SWAP_RDB,
    S_SWAP_WI,
    S_SWAP_WB,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [ValW-1:0]   value;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] count;
    logic              last;
  } result_t;

endpackage

FILE: hw/rtl/bls_if.sv
interface bls_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [bls_pkg::OpW-1:0]           opcode;
  logic signed [bls_pkg::ValW-1:0]   operand_value;
  modport source (output valid, opcode, operand_value, input ready);
  modport sink (input valid, opcode, operand_value, output ready);
endinterface

interface bls_res_if;
  logic                              valid;
  logic                              ready;
  logic [bls_pkg::StatW-1:0]         status;
  logic signed [bls_pkg::ValW-1:0]   result_value;
  logic [bls_pkg::PosW-1:0]          position;
  logic [bls_pkg::CountW-1:0]        entry_count;
  logic                              last_result;
  modport source (output valid, status, result_value, position, entry_count, last_result,
                  input ready);
  modport sink (input valid, status, result_value, position, entry_count, last_result,
                output ready);
endinterface

FILE: hw/rtl/bls_ram.sv
module bls_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hw/rtl/bounded_list_store_with_sort_core.sv
// Ordered list of up to Capacity signed 32-bit words in a single-port-write
// RAM with registered read, driven by a small sequencer; one command at a time,
// ready only when idle. Clear, tail insert/delete and unused opcodes answer
// straight from idle; head insert/delete and search delete shift words one at a
// time; search scans the list word by word; sort is a selection sort; dump emits
// one result per entry and waits on the result side. All list walks go through
// the one RAM read port.
// The result word sits in an output register and is held until taken.
module bounded_list_store_with_sort_core #(
  parameter int unsigned Capacity = bls_pkg::Capacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  bls_cmd_if.sink   cmd,
  bls_res_if.source res
);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned LW = $clog2(Capacity + 1);

  bls_pkg::state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] i_q, i_d, j_q, j_d, best_q, best_d;
  logic [bls_pkg::ValW-1:0] val_q, val_d, tmp_q, tmp_d;
  logic [bls_pkg::OpW-1:0] op_q, op_d;
  bls_pkg::result_t out_q, out_d;
  logic out_vld_q, out_vld_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [bls_pkg::ValW-1:0] wdata, rdata;

  bls_ram #(.Width(bls_pkg::ValW), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // shared signed comparator: rdata against held word
  logic lt, eq;
  assign lt = $signed(rdata) < $signed(tmp_q);
  assign eq = rdata == val_q;

  function automatic logic [bls_pkg::PosW-1:0] pos4(logic [LW-1:0] x);
    logic [LW+bls_pkg::PosW-1:0] w;
    w = {{bls_pkg::PosW{1'b0}}, x};
    return w[bls_pkg::PosW-1:0];
  endfunction

  function automatic logic [bls_pkg::CountW-1:0] cnt5(logic [LW-1:0] x);
    logic [LW+bls_pkg::CountW-1:0] w;
    w = {{bls_pkg::CountW{1'b0}}, x};
    return w[bls_pkg::CountW-1:0];
  endfunction

  assign cmd.ready        = (state_q == bls_pkg::S_IDLE) && !out_vld_q;
  assign res.valid        = out_vld_q;
  assign res.status       = out_q.status;
  assign res.result_value = out_q.value;
  assign res.position     = out_q.position;
  assign res.entry_count  = out_q.count;
  assign res.last_result  = out_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bls_pkg::S_IDLE;
      len_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    best_q <= best_d;
    val_q  <= val_d;
    tmp_q  <= tmp_d;
    op_q   <= op_d;
    out_q  <= out_d;
  end

  // emit one result word into the output register
  task automatic emit(input logic [bls_pkg::StatW-1:0] st, input logic [bls_pkg::ValW-1:0] v,
                      input logic [LW-1:0] p, input logic [LW-1:0] n, input logic lst);
    out_d.status   = st;
    out_d.value    = v;
    out_d.position = pos4(p);
    out_d.count    = cnt5(n);
    out_d.last     = lst;
    out_vld_d      = 1'b1;
  endtask

  logic is_desc;
  assign is_desc = op_q == bls_pkg::OP_SORT_DN;

  always_comb begin
    logic better;
    state_d   = state_q;
    len_d     = len_q;
    i_d       = i_q;
    j_d       = j_q;
    best_d    = best_q;
    val_d     = val_q;
    tmp_d     = tmp_q;
    op_d      = op_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !res.ready;
    we        = 1'b0;
    waddr     = '0;
    wdata     = val_q;
    raddr     = '0;
    better    = is_desc ? (!lt && !(rdata == tmp_q)) : lt;

    unique case (state_q)
      bls_pkg::S_IDLE: begin
        if (cmd.valid && cmd.ready) begin
          op_d  = cmd.opcode;
          val_d = cmd.operand_value;
          unique case (cmd.opcode)
            bls_pkg::OP_CLEAR: begin
              len_d = '0;
              emit(bls_pkg::ST_OK, '0, '0, '0, 1'b1);
            end
            bls_pkg::OP_INS_HEAD, bls_pkg::OP_INS_TAIL: begin
              if (len_q == LW'(Capacity)) begin
                emit(bls_pkg::ST_FULL, '0, '0, len_q, 1'b1);
              end else if (cmd.opcode == bls_pkg::OP_INS_TAIL || len_q == '0) begin
                we    = 1'b1;
                waddr = len_q[AW-1:0];
                wdata = cmd.operand_value;
                len_d = len_q + 1'b1;
                emit(bls_pkg::ST_OK, '0, '0, len_q + 1'b1, 1'b1);
              end else begin
                // walk from the tail moving each word up one place
                i_d     = len_q;
                state_d = bls_pkg::S_SHIFT_RD;
              end
            end
            bls_pkg::OP_DEL_HEAD, bls_pkg::OP_DEL_TAIL: begin
              if (len_q == '0) begin
                emit(bls_pkg::ST_EMPTY, '0, '0, len_q, 1'b1);
              end else if (cmd.opcode == bls_pkg::OP_DEL_TAIL) begin
                len_d = len_q - 1'b1;
                emit(bls_pkg::ST_OK, '0, '0, len_q - 1'b1, 1'b1);
              end else begin
                best_d  = '0;
                i_d     = '0;
                state_d = bls_pkg::S_SHIFT_RD;
              end
            end
            bls_pkg::OP_SEARCH, bls_pkg::OP_SRCH_DEL: begin
              i_d     = '0;
              state_d = bls_pkg::S_FIND_RD;
            end
            bls_pkg::OP_SORT_UP, bls_pkg::OP_SORT_DN: begin
              i_d     = '0;
              state_d = bls_pkg::S_SORT_RD;
            end
            bls_pkg::OP_DUMP: begin
              if (len_q == '0) begin
                emit(bls_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
              end else begin
                i_d     = '0;
                state_d = bls_pkg::S_DUMP_RD;
              end
            end
            default: emit(bls_pkg::ST_OK, '0, '0, len_q, 1'b1);
          endcase
        end
      end

      // head insert moves down from the tail; removal moves up from best_q
      bls_pkg::S_SHIFT_RD: begin
        if (op_q == bls_pkg::OP_INS_HEAD) begin
          if (i_q == '0) begin
            we      = 1'b1;
            waddr   = '0;
            wdata   = val_q;
            len_d   = len_q + 1'b1;
            state_d = bls_pkg::S_RESP;
          end else begin
            raddr   = AW'(i_q - 1'b1);
            state_d = bls_pkg::S_SHIFT_WR;
          end
        end else begin
          if (i_q + 1'b1 >= len_q) begin
            len_d   = len_q - 1'b1;
            state_d = bls_pkg::S_RESP;
          end else begin
            raddr   = AW'(i_q + 1'b1);
            state_d = bls_pkg::S_SHIFT_WR;
          end
        end
      end

      bls_pkg::S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = i_q[AW-1:0];
        wdata = rdata;
        i_d   = (op_q == bls_pkg::OP_INS_HEAD) ? i_q - 1'b1 : i_q + 1'b1;
        state_d = bls_pkg::S_SHIFT_RD;
      end

      bls_pkg::S_FIND_RD: begin
        if (i_q >= len_q) begin
          emit(bls_pkg::ST_EMPTY, '0, '0, len_q, 1'b1);
          state_d = bls_pkg::S_IDLE;
        end else begin
          raddr   = i_q[AW-1:0];
          state_d = bls_pkg::S_FIND_CMP;
        end
      end

      bls_pkg::S_FIND_CMP: begin
        if (eq) begin
          if (op_q == bls_pkg::OP_SEARCH) begin
            emit(bls_pkg::ST_OK, '0, i_q, len_q, 1'b1);
            state_d = bls_pkg::S_IDLE;
          end else begin
            best_d  = i_q;
            state_d = bls_pkg::S_SHIFT_RD;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = bls_pkg::S_FIND_RD;
        end
      end

      // selection sort: tmp_q holds current best word, best_q its index
      bls_pkg::S_SORT_RD: begin
        if (i_q + 1'b1 >= len_q || len_q == '0) begin
          emit(bls_pkg::ST_OK, '0, '0, len_q, 1'b1);
          state_d = bls_pkg::S_IDLE;
        end else begin
          raddr   = i_q[AW-1:0];
          best_d  = i_q;
          j_d     = i_q;
          state_d = bls_pkg::S_SORT_CMP;
        end
      end

      bls_pkg::S_SORT_CMP: begin
        if (j_q == i_q) begin
          tmp_d = rdata;
          val_d = rdata;
        end else if (better) begin
          tmp_d  = rdata;
          best_d = j_q;
        end
        if (j_q + 1'b1 >= len_q) begin
          state_d = bls_pkg::S_SWAP_RDB;
        end else begin
          raddr = AW'(j_q + 1'b1);
          j_d   = j_q + 1'b1;
        end
      end

      // val_q holds word at i, tmp_q the chosen word
      bls_pkg::S_SWAP_RDB: state_d = bls_pkg::S_SWAP_WI;

      bls_pkg::S_SWAP_WI: begin
        we      = 1'b1;
        waddr   = i_q[AW-1:0];
        wdata   = tmp_q;
        state_d = bls_pkg::S_SWAP_WB;
      end

      bls_pkg::S_SWAP_WB: begin
        we      = 1'b1;
        waddr   = best_q[AW-1:0];
        wdata   = (best_q == i_q) ? tmp_q : val_q;
        i_d     = i_q + 1'b1;
        state_d = bls_pkg::S_SORT_RD;
      end

      bls_pkg::S_DUMP_RD: begin
        raddr   = i_q[AW-1:0];
        state_d = bls_pkg::S_DUMP_OUT;
      end

      bls_pkg::S_DUMP_OUT: begin
        if (!out_vld_q || res.ready) begin
          emit(bls_pkg::ST_OK, rdata, i_q, len_q,
               (i_q + 1'b1 == len_q) || (i_q + 1'b1 == LW'(bls_pkg::MaxResults)));
          if ((i_q + 1'b1 == len_q) || (i_q + 1'b1 == LW'(bls_pkg::MaxResults))) begin
            state_d = bls_pkg::S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = bls_pkg::S_DUMP_RD;
          end
        end else begin
          raddr = i_q[AW-1:0];
        end
      end

      bls_pkg::S_RESP: begin
        emit(bls_pkg::ST_OK, '0, (op_q == bls_pkg::OP_SRCH_DEL) ? best_q : '0, len_q, 1'b1);
        state_d = bls_pkg::S_IDLE;
      end

      default: state_d = bls_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(Capacity)) else $error("length exceeds capacity");
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != bls_pkg::S_IDLE |-> !cmd.ready) else $error("ready while busy");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res.ready |=> out_vld_q && $stable(out_q)) else $error("result lost");
  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q != $past(len_q) |-> len_q == '0 || len_q == $past(len_q) + 1'b1 ||
    len_q == $past(len_q) - 1'b1) else $error("length jumped");
`endif
endmodule
